### rtl/brgap_pkg.sv
// ----------------------------------------------------------------------------
// brgap_pkg
// Shared types, constants and helpers for the bridge power averaging and
// PWM gap regulation block.
// ----------------------------------------------------------------------------
package brgap_pkg;

  // averaging depth of both rings
  localparam int AVG_DEPTH = 4;
  localparam int IDX_W     = $clog2(AVG_DEPTH);

  localparam int SAMPLE_W  = 12;
  localparam int PERIOD_W  = 15;
  localparam int GAP_W     = 9;
  localparam int COMPARE_W = 14;
  localparam int SUM_W     = SAMPLE_W + IDX_W;

  // exact truncating mean via reciprocal multiply: m = ceil(2^(N+l) / d)
  localparam int MEAN_K  = SUM_W + IDX_W;
  localparam int RECIP   = ((1 << MEAN_K) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int RECIP_W = MEAN_K - IDX_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;

  localparam logic [COMPARE_W-1:0] COMPARE_MAX = '1;

  // reset values of the registers and of the gap
  localparam logic [PERIOD_W-1:0] PERIOD_RESET          = PERIOD_W'(500);
  localparam logic [SAMPLE_W-1:0] POWER_THRESHOLD_RESET = SAMPLE_W'(1400);
  localparam logic [SAMPLE_W-1:0] SHORT_THRESHOLD_RESET = SAMPLE_W'(250);
  localparam logic [GAP_W-1:0]    GAP_LOW_LIMIT_RESET   = GAP_W'(100);
  localparam logic [GAP_W-1:0]    GAP_HIGH_LIMIT_RESET  = GAP_W'(300);
  localparam logic [GAP_W-1:0]    GAP_RESET             = GAP_W'(100);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PERIOD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD          = 3'd0,
    REG_POWER_THRESHOLD = 3'd1,
    REG_SHORT_THRESHOLD = 3'd2,
    REG_GAP_LOW_LIMIT   = 3'd3,
    REG_GAP_HIGH_LIMIT  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [SAMPLE_W-1:0] power_threshold;
    logic [SAMPLE_W-1:0] short_threshold;
    logic [GAP_W-1:0]    gap_low_limit;
    logic [GAP_W-1:0]    gap_high_limit;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                loaded;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  offset_mean;
    logic [SAMPLE_W-1:0]  power_mean;
    logic [GAP_W-1:0]     gap_now;
    logic [COMPARE_W-1:0] compare_a;
    logic [COMPARE_W-1:0] compare_b;
    logic                 short_fault;
  } result_t;

  function automatic logic [SAMPLE_W-1:0] mean_of(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(RECIP);
    return SAMPLE_W'(prod >> MEAN_K);
  endfunction

endpackage

### rtl/bridge_power_average_gap_regulator.sv
// ----------------------------------------------------------------------------
// bridge_power_average_gap_regulator
// Offset and power averaging of bridge current samples with PWM gap control.
// ----------------------------------------------------------------------------
// an input transfer is captured in the input register, which feeds the
//   result register whenever the result register is empty or being drained
// throughput: one item per cycle while result_stall is low; the ring update,
//   gap step and compare values run in one pass from input to result register
// reset (rst, synchronous, active high): rings, means, ring index cleared,
//   gap to 100, registers to their defaults, both pipeline stages emptied
module bridge_power_average_gap_regulator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  brgap_pkg::item_t                 item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output brgap_pkg::result_t               result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [brgap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brgap_pkg::CFG_DATA_W-1:0] cfg_data
);

  brgap_pkg::cfg_t                cfg;
  brgap_pkg::item_t               hold;
  logic                           hold_valid;
  logic                           advance;
  logic                           fire;
  logic [brgap_pkg::IDX_W-1:0]    ring_index;
  logic [brgap_pkg::IDX_W-1:0]    index_adv;
  logic [brgap_pkg::SAMPLE_W-1:0] offset_mean;
  logic [brgap_pkg::SAMPLE_W-1:0] offset_next;
  logic [brgap_pkg::SAMPLE_W-1:0] power_mean;
  logic [brgap_pkg::SAMPLE_W-1:0] power_next;
  logic [brgap_pkg::SAMPLE_W-1:0] power_in;
  brgap_pkg::result_t             result_next;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period          <= brgap_pkg::PERIOD_RESET;
      cfg.power_threshold <= brgap_pkg::POWER_THRESHOLD_RESET;
      cfg.short_threshold <= brgap_pkg::SHORT_THRESHOLD_RESET;
      cfg.gap_low_limit   <= brgap_pkg::GAP_LOW_LIMIT_RESET;
      cfg.gap_high_limit  <= brgap_pkg::GAP_HIGH_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        brgap_pkg::REG_PERIOD:          cfg.period <= cfg_data;
        brgap_pkg::REG_POWER_THRESHOLD: cfg.power_threshold <= cfg_data[11:0];
        brgap_pkg::REG_SHORT_THRESHOLD: cfg.short_threshold <= cfg_data[11:0];
        brgap_pkg::REG_GAP_LOW_LIMIT:   cfg.gap_low_limit <= cfg_data[8:0];
        brgap_pkg::REG_GAP_HIGH_LIMIT:  cfg.gap_high_limit <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // result register can take a new item when empty or being drained
  assign advance    = !result_valid || !result_stall;
  assign item_stall = rst || (hold_valid && !advance);
  assign fire       = hold_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!item_stall) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      hold <= item;
    end
  end

  assign index_adv = (ring_index == brgap_pkg::IDX_W'(brgap_pkg::AVG_DEPTH - 1))
                     ? '0 : ring_index + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_index <= '0;
    end else if (fire && !hold.loaded) begin
      ring_index <= index_adv;
    end
  end

  // offset-corrected load value, floored at zero
  assign power_in = (hold.sample < offset_mean) ? offset_mean - hold.sample : '0;

  brgap_ring u_offset_ring (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (fire && !hold.loaded),
    .wr_idx    (index_adv),
    .wr_data   (hold.sample),
    .mean      (offset_mean),
    .mean_next (offset_next)
  );

  brgap_ring u_power_ring (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (fire && hold.loaded),
    .wr_idx    (ring_index),
    .wr_data   (power_in),
    .mean      (power_mean),
    .mean_next (power_next)
  );

  brgap_gap u_gap (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step_en    (fire && hold.loaded),
    .sample     (hold.sample),
    .power_next (power_next),
    .gap_now    (result_next.gap_now),
    .compare_a  (result_next.compare_a),
    .compare_b  (result_next.compare_b),
    .fault      (result_next.short_fault)
  );

  assign result_next.offset_mean = offset_next;
  assign result_next.power_mean  = power_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> hold_valid && result_valid && result_stall)
    else $error("input stalled with room in the pipeline");

  a_idle_no_fault: assert property (@(posedge clk) disable iff (rst)
    fire && !hold.loaded |=> !result.short_fault && result.power_mean == $past(power_mean))
    else $error("idle transfer changed power or flagged a short");

  a_compare_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.compare_b <= result.compare_a)
    else $error("compare values out of order");

endmodule

### rtl/brgap_ring.sv
// ----------------------------------------------------------------------------
// brgap_ring
// Averaging ring with a running sum; gives the mean before and after a write.
// ----------------------------------------------------------------------------
module brgap_ring (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [brgap_pkg::IDX_W-1:0]    wr_idx,
  input  logic [brgap_pkg::SAMPLE_W-1:0] wr_data,
  output logic [brgap_pkg::SAMPLE_W-1:0] mean,
  output logic [brgap_pkg::SAMPLE_W-1:0] mean_next
);

  logic [brgap_pkg::SAMPLE_W-1:0] ring [brgap_pkg::AVG_DEPTH];
  logic [brgap_pkg::SUM_W-1:0]    sum;
  logic [brgap_pkg::SUM_W-1:0]    sum_next;

  // swap the overwritten entry out of the running sum
  always_comb begin
    sum_next = sum;
    if (wr_en) begin
      sum_next = sum - brgap_pkg::SUM_W'(ring[wr_idx])
                 + brgap_pkg::SUM_W'(wr_data);
    end
  end

  assign mean_next = brgap_pkg::mean_of(sum_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < brgap_pkg::AVG_DEPTH; k++) begin
        ring[k] <= '0;
      end
      sum  <= '0;
      mean <= '0;
    end else if (wr_en) begin
      ring[wr_idx] <= wr_data;
      sum          <= sum_next;
      mean         <= mean_next;
    end
  end

  a_mean_tracks_sum: assert property (@(posedge clk) disable iff (rst)
    mean == brgap_pkg::mean_of(sum))
    else $error("ring mean out of step with running sum");

endmodule

### rtl/brgap_gap.sv
// ----------------------------------------------------------------------------
// brgap_gap
// Gap step, clamp and short-circuit override; PWM compare values.
// ----------------------------------------------------------------------------
module brgap_gap (
  input  logic                            clk,
  input  logic                            rst,
  input  brgap_pkg::cfg_t                 cfg,
  input  logic                            step_en,
  input  logic [brgap_pkg::SAMPLE_W-1:0]  sample,
  input  logic [brgap_pkg::SAMPLE_W-1:0]  power_next,
  output logic [brgap_pkg::GAP_W-1:0]     gap_now,
  output logic [brgap_pkg::COMPARE_W-1:0] compare_a,
  output logic [brgap_pkg::COMPARE_W-1:0] compare_b,
  output logic                            fault
);

  logic [brgap_pkg::GAP_W-1:0]    gap;
  logic [brgap_pkg::GAP_W-1:0]    gap_next;
  logic [brgap_pkg::GAP_W:0]      stepped;
  logic [brgap_pkg::GAP_W:0]      capped;
  logic [brgap_pkg::GAP_W:0]      floored;
  logic                           is_short;
  logic [brgap_pkg::PERIOD_W:0]   sum_a;
  logic [brgap_pkg::PERIOD_W-1:0] diff_b;

  always_comb begin
    if (power_next > cfg.power_threshold) begin
      stepped = {1'b0, gap} + 1'b1;
    end else if (gap != '0) begin
      stepped = {1'b0, gap} - 1'b1;
    end else begin
      stepped = '0;
    end
    // high limit first, so the low limit wins when the two cross
    capped  = (stepped > {1'b0, cfg.gap_high_limit}) ? {1'b0, cfg.gap_high_limit} : stepped;
    floored = (capped < {1'b0, cfg.gap_low_limit}) ? {1'b0, cfg.gap_low_limit} : capped;
    is_short = sample < cfg.short_threshold;
    gap_next = is_short ? cfg.gap_low_limit : floored[brgap_pkg::GAP_W-1:0];
  end

  assign gap_now = step_en ? gap_next : gap;
  assign fault   = step_en && is_short;

  always_comb begin
    sum_a  = {1'b0, cfg.period} + (brgap_pkg::PERIOD_W + 1)'(gap_now);
    diff_b = cfg.period - brgap_pkg::PERIOD_W'(gap_now);
    if (sum_a[brgap_pkg::PERIOD_W]) begin
      compare_a = brgap_pkg::COMPARE_MAX;
    end else begin
      compare_a = sum_a[brgap_pkg::PERIOD_W-1:1];
    end
    if (cfg.period >= brgap_pkg::PERIOD_W'(gap_now)) begin
      compare_b = diff_b[brgap_pkg::PERIOD_W-1:1];
    end else begin
      compare_b = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= brgap_pkg::GAP_RESET;
    end else if (step_en) begin
      gap <= gap_next;
    end
  end

  a_short_forces_low: assert property (@(posedge clk) disable iff (rst)
    fault |=> gap == $past(cfg.gap_low_limit))
    else $error("short did not force the low gap limit");

  a_gap_in_range: assert property (@(posedge clk) disable iff (rst)
    step_en && cfg.gap_low_limit <= cfg.gap_high_limit
    |=> gap >= $past(cfg.gap_low_limit) && gap <= $past(cfg.gap_high_limit))
    else $error("gap left its limits");

endmodule
